// ===== design/textured_quad_scissor_uv_clip_top_macros.svh =====
// Assertion helpers for the scissor clip block.
// Both expect clk and rst_n in the scope where they are used.
`ifndef TEXTURED_QUAD_SCISSOR_UV_CLIP_TOP_MACROS_SVH
`define TEXTURED_QUAD_SCISSOR_UV_CLIP_TOP_MACROS_SVH

// Check a consequence in the same cycle as its cause.
`define TQC_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its cause.
`define TQC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/tqc_pkg.sv =====
`default_nettype none

package tqc_pkg;

    // Field widths
    localparam int COORD_W = 16;
    localparam int SIZE_W  = 15;
    localparam int TEX_W   = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCISSOR_X      = 2'd0,
        CFG_SCISSOR_Y      = 2'd1,
        CFG_SCISSOR_WIDTH  = 2'd2,
        CFG_SCISSOR_HEIGHT = 2'd3
    } cfg_index_t;

    localparam logic signed [COORD_W-1:0] SCISSOR_POS_RESET  = '0;
    localparam logic        [SIZE_W-1:0]  SCISSOR_SIZE_RESET = '1;

    // Pipeline shape: ends, overlap, product, divider stages, output
    localparam int BITS_PER_STEP = 2;
    localparam int DIV_STEPS     = TEX_W / BITS_PER_STEP;
    localparam int ST_PROD       = 2;
    localparam int NS            = DIV_STEPS + 4;

    // Per-axis span tests, seen by the top level to make the clip decision
    typedef struct packed {
        logic touch;
        logic contained;
    } axis_flags_t;

    // Restoring divider word: partial remainder over dividend/quotient bits
    typedef struct packed {
        logic [SIZE_W-1:0] rem;
        logic [TEX_W-1:0]  low;
    } div_word_t;

    // One quotient bit: shift in the next dividend bit, subtract if it fits
    function automatic div_word_t div_step(div_word_t w, logic [SIZE_W-1:0] qs);
        logic [SIZE_W:0] trial;
        logic [SIZE_W:0] diff;
        div_word_t       r;
        trial = {w.rem, w.low[TEX_W-1]};
        diff  = trial - {1'b0, qs};
        if (trial >= {1'b0, qs})
        begin
            r.rem = diff[SIZE_W-1:0];
            r.low = {w.low[TEX_W-2:0], 1'b1};
        end
        else
        begin
            r.rem = trial[SIZE_W-1:0];
            r.low = {w.low[TEX_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/tqc_if.sv =====
`default_nettype none

// Quad item: screen quad and its texture rectangle
interface tqc_quad_if;
    import tqc_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] quad_x;
    logic signed [COORD_W-1:0] quad_y;
    logic        [SIZE_W-1:0]  quad_width;
    logic        [SIZE_W-1:0]  quad_height;
    logic        [TEX_W-1:0]   tex_x;
    logic        [TEX_W-1:0]   tex_y;
    logic        [TEX_W-1:0]   tex_width;
    logic        [TEX_W-1:0]   tex_height;

    modport source (
        output valid, quad_x, quad_y, quad_width, quad_height,
               tex_x, tex_y, tex_width, tex_height,
        input  ready
    );

    modport sink (
        input  valid, quad_x, quad_y, quad_width, quad_height,
               tex_x, tex_y, tex_width, tex_height,
        output ready
    );
endinterface

// Result item: clipped texture rectangle
interface tqc_result_if;
    import tqc_pkg::*;

    logic             valid;
    logic             ready;
    logic [TEX_W-1:0] out_tex_x;
    logic [TEX_W-1:0] out_tex_y;
    logic [TEX_W-1:0] out_tex_width;
    logic [TEX_W-1:0] out_tex_height;
    logic             was_clipped;

    modport source (
        output valid, out_tex_x, out_tex_y, out_tex_width, out_tex_height, was_clipped,
        input  ready
    );

    modport sink (
        input  valid, out_tex_x, out_tex_y, out_tex_width, out_tex_height, was_clipped,
        output ready
    );
endinterface

`default_nettype wire

// ===== design/textured_quad_scissor_uv_clip_top.sv =====
// Channel   Dir  Handshake     Carries
// quad      in   valid/ready   quad position and size, texture rectangle
// result    out  valid/ready   clipped texture rectangle, was_clipped flag
// cfg       in   cfg_we        scissor_x, scissor_y, scissor_width, scissor_height
//
// Takes one item per cycle unless the result stalls; items pass the span,
// overlap, product, restoring divider (two quotient bits a stage) and output.
// Reset clears the stage valid bits and loads the scissor reset values.
// Every stage has its own valid bit; a stalled result holds only the stages
// behind it that are full, so empty stages keep filling.
`default_nettype none
`include "textured_quad_scissor_uv_clip_top_macros.svh"

module textured_quad_scissor_uv_clip_top (
    input  logic                              clk,
    input  logic                              rst_n,
    tqc_quad_if.sink                          quad,
    tqc_result_if.source                      result,
    input  logic                              cfg_we,
    input  logic [tqc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tqc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import tqc_pkg::*;

    // Scissor registers
    logic signed [COORD_W-1:0] scissor_x_reg;
    logic signed [COORD_W-1:0] scissor_y_reg;
    logic [SIZE_W-1:0]         scissor_width_reg;
    logic [SIZE_W-1:0]         scissor_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scissor_x_reg      <= SCISSOR_POS_RESET;
            scissor_y_reg      <= SCISSOR_POS_RESET;
            scissor_width_reg  <= SCISSOR_SIZE_RESET;
            scissor_height_reg <= SCISSOR_SIZE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_SCISSOR_X:      scissor_x_reg      <= cfg_data[COORD_W-1:0];
                CFG_SCISSOR_Y:      scissor_y_reg      <= cfg_data[COORD_W-1:0];
                CFG_SCISSOR_WIDTH:  scissor_width_reg  <= cfg_data[SIZE_W-1:0];
                CFG_SCISSOR_HEIGHT: scissor_height_reg <= cfg_data[SIZE_W-1:0];
                default:            scissor_x_reg      <= scissor_x_reg;
            endcase
        end
    end

    // Stage enables: a stage advances when empty or when the next one advances
    logic [NS-1:0] v_reg;
    logic [NS-1:0] en;

    assign en[NS-1] = !v_reg[NS-1] || result.ready;

    for (genvar i = 0; i < NS-1; i++)
    begin : g_en
        assign en[i] = !v_reg[i] || en[i+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= quad.valid;
            end
            for (int i = 1; i < NS; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    assign quad.ready   = en[0];
    assign result.valid = v_reg[NS-1];

    // Axis datapaths
    axis_flags_t      flags_x;
    axis_flags_t      flags_y;
    logic             do_clip;
    logic [TEX_W-1:0] start_x;
    logic [TEX_W-1:0] size_x;
    logic [TEX_W-1:0] start_y;
    logic [TEX_W-1:0] size_y;

    assign do_clip = flags_x.touch && flags_y.touch &&
                     !(flags_x.contained && flags_y.contained);

    tqc_axis u_axis_x (
        .clk       (clk),
        .en        (en),
        .q0        (quad.quad_x),
        .qs        (quad.quad_width),
        .s0        (scissor_x_reg),
        .ss        (scissor_width_reg),
        .t0        (quad.tex_x),
        .ts        (quad.tex_width),
        .do_clip   (do_clip),
        .flags     (flags_x),
        .tex_start (start_x),
        .tex_size  (size_x)
    );

    tqc_axis u_axis_y (
        .clk       (clk),
        .en        (en),
        .q0        (quad.quad_y),
        .qs        (quad.quad_height),
        .s0        (scissor_y_reg),
        .ss        (scissor_height_reg),
        .t0        (quad.tex_y),
        .ts        (quad.tex_height),
        .do_clip   (do_clip),
        .flags     (flags_y),
        .tex_start (start_y),
        .tex_size  (size_y)
    );

    // Carry the clip decision down to the output stage
    logic [NS-1:1] clip_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            clip_reg[1] <= do_clip;
        end
        for (int i = 2; i < NS; i++)
        begin
            if (en[i])
            begin
                clip_reg[i] <= clip_reg[i-1];
            end
        end
    end

    assign result.out_tex_x      = start_x;
    assign result.out_tex_y      = start_y;
    assign result.out_tex_width  = size_x;
    assign result.out_tex_height = size_y;
    assign result.was_clipped    = clip_reg[NS-1];

    // Checks
    `TQC_ASSERT_NOW(a_ready_when_empty, !v_reg[0], quad.ready, "empty first stage refused an item")
    `TQC_ASSERT_NEXT(a_accept_fills, quad.valid && quad.ready, v_reg[0], "accepted item was lost")
    `TQC_ASSERT_NEXT(a_stall_holds, v_reg[NS-1] && !result.ready, v_reg[NS-1], "stalled result dropped")

endmodule

`default_nettype wire

// ===== design/tqc_axis.sv =====
`default_nettype none

// One axis of the clip: span tests, overlap, scaled texture start and size.
// Stage enables come from the top level; this module holds payload only.
module tqc_axis (
    input  logic                               clk,
    input  logic [tqc_pkg::NS-1:0]             en,
    input  logic signed [tqc_pkg::COORD_W-1:0] q0,
    input  logic [tqc_pkg::SIZE_W-1:0]         qs,
    input  logic signed [tqc_pkg::COORD_W-1:0] s0,
    input  logic [tqc_pkg::SIZE_W-1:0]         ss,
    input  logic [tqc_pkg::TEX_W-1:0]          t0,
    input  logic [tqc_pkg::TEX_W-1:0]          ts,
    input  logic                               do_clip,
    output tqc_pkg::axis_flags_t               flags,
    output logic [tqc_pkg::TEX_W-1:0]          tex_start,
    output logic [tqc_pkg::TEX_W-1:0]          tex_size
);
    import tqc_pkg::*;

    typedef struct packed {
        logic [SIZE_W-1:0] ov;
        logic [SIZE_W-1:0] qs;
        logic [TEX_W-1:0]  t0;
        logic [TEX_W-1:0]  ts;
        logic              apply;
        logic              move;
    } ovl_t;

    typedef struct packed {
        div_word_t         w;
        logic [SIZE_W-1:0] qs;
        logic [TEX_W-1:0]  t0;
        logic [TEX_W-1:0]  ts;
        logic              apply;
        logic              move;
    } div_slot_t;

    // Stage 0: span ends
    logic signed [COORD_W:0] q0_reg;
    logic signed [COORD_W:0] q1_reg;
    logic signed [COORD_W:0] s0_reg;
    logic signed [COORD_W:0] s1_reg;
    logic [SIZE_W-1:0]       qs_reg;
    logic [TEX_W-1:0]        t0_reg;
    logic [TEX_W-1:0]        ts_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            q0_reg <= {q0[COORD_W-1], q0};
            q1_reg <= $signed({q0[COORD_W-1], q0}) + $signed({1'b0, 1'b0, qs});
            s0_reg <= {s0[COORD_W-1], s0};
            s1_reg <= $signed({s0[COORD_W-1], s0}) + $signed({1'b0, 1'b0, ss});
            qs_reg <= qs;
            t0_reg <= t0;
            ts_reg <= ts;
        end
    end

    // Span tests on inclusive bounds
    logic start_in;
    logic end_in;
    logic covers;

    assign start_in        = (q0_reg >= s0_reg) && (q0_reg <= s1_reg);
    assign end_in          = (q1_reg >= s0_reg) && (q1_reg <= s1_reg);
    assign covers          = (q0_reg <= s0_reg) && (q1_reg >= s1_reg);
    assign flags.touch     = start_in || end_in || covers;
    assign flags.contained = start_in && end_in;

    // Stage 1: overlap length, clamped to the quad size
    logic signed [COORD_W:0] lo;
    logic signed [COORD_W:0] hi;
    logic signed [COORD_W:0] span_diff;
    logic signed [COORD_W:0] ov_wide;
    ovl_t                    ovl_next;
    ovl_t                    ovl_reg;

    always_comb
    begin
        lo        = (q0_reg > s0_reg) ? q0_reg : s0_reg;
        hi        = (q1_reg < s1_reg) ? q1_reg : s1_reg;
        span_diff = hi - lo;
        ov_wide   = (hi > lo) ? span_diff : '0;
        ovl_next.ov    = (ov_wide > $signed({1'b0, 1'b0, qs_reg})) ? qs_reg
                                                                    : ov_wide[SIZE_W-1:0];
        ovl_next.qs    = qs_reg;
        ovl_next.t0    = t0_reg;
        ovl_next.ts    = ts_reg;
        ovl_next.apply = do_clip && (qs_reg != '0);
        ovl_next.move  = !start_in;
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            ovl_reg <= ovl_next;
        end
    end

    // Stage 2: product overlap * texture size; stages after: divide by quad size
    logic [SIZE_W+TEX_W-1:0] prod;
    div_slot_t               slot_reg  [0:DIV_STEPS];
    div_slot_t               slot_next [1:DIV_STEPS];

    assign prod = ovl_reg.ov * ovl_reg.ts;

    always_comb
    begin
        for (int j = 1; j <= DIV_STEPS; j++)
        begin
            slot_next[j] = slot_reg[j-1];
            for (int b = 0; b < BITS_PER_STEP; b++)
            begin
                slot_next[j].w = div_step(slot_next[j].w, slot_next[j].qs);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_PROD])
        begin
            slot_reg[0].w     <= div_word_t'(prod);
            slot_reg[0].qs    <= ovl_reg.qs;
            slot_reg[0].t0    <= ovl_reg.t0;
            slot_reg[0].ts    <= ovl_reg.ts;
            slot_reg[0].apply <= ovl_reg.apply;
            slot_reg[0].move  <= ovl_reg.move;
        end
        for (int j = 1; j <= DIV_STEPS; j++)
        begin
            if (en[ST_PROD+j])
            begin
                slot_reg[j] <= slot_next[j];
            end
        end
    end

    // Output stage: cut part is ts - ceil(ov*ts/qs); saturate the moved start
    div_slot_t        last;
    logic             rem_nz;
    logic [TEX_W-1:0] cut;
    logic [TEX_W:0]   start_sum;
    logic [TEX_W-1:0] start_sat;
    logic [TEX_W-1:0] tex_start_next;
    logic [TEX_W-1:0] tex_size_next;
    logic [TEX_W-1:0] tex_start_reg;
    logic [TEX_W-1:0] tex_size_reg;

    always_comb
    begin
        last      = slot_reg[DIV_STEPS];
        rem_nz    = (last.w.rem != '0);
        cut       = last.ts - last.w.low - {{(TEX_W-1){1'b0}}, rem_nz};
        start_sum = {1'b0, last.t0} + {1'b0, cut};
        start_sat = start_sum[TEX_W] ? '1 : start_sum[TEX_W-1:0];
        if (last.apply)
        begin
            tex_start_next = last.move ? start_sat : last.t0;
            tex_size_next  = last.w.low;
        end
        else
        begin
            tex_start_next = last.t0;
            tex_size_next  = last.ts;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[NS-1])
        begin
            tex_start_reg <= tex_start_next;
            tex_size_reg  <= tex_size_next;
        end
    end

    assign tex_start = tex_start_reg;
    assign tex_size  = tex_size_reg;

endmodule

`default_nettype wire
